// ----- src/nufm_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: shared package
// Table sizes, field widths, sequencer states and the structs passed
// between the sequencer, the table memory and the compare unit.
// ----------------------------------------------------------------------------
package nufm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FREQ_W      = 24;
    localparam int ENTRY_W     = 8;
    localparam int LEN_W       = 9;
    localparam int KEY_W       = FREQ_W + 1;

    localparam logic [KEY_W-1:0] HALF_HZ = KEY_W'(128);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS_RD,
        ST_BS_CMP,
        ST_SC_RD,
        ST_SC_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [FREQ_W-1:0] wfreq;
        logic              wused;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              used;
    } t_mem_rsp;

    typedef struct packed {
        logic              below_lo;
        logic              below_hi;
        logic [FREQ_W-1:0] diff;
    } t_cmp_res;

endpackage

// ----- src/nufm_if.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: channel interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface nufm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [nufm_pkg::ENTRY_W-1:0] entry_index;
    logic [nufm_pkg::FREQ_W-1:0]  frequency;
    logic                         entry_used;
    logic [nufm_pkg::LEN_W-1:0]   table_length;

    modport source (output valid, mode, entry_index, frequency, entry_used, table_length,
                    input ready);
    modport sink   (input valid, mode, entry_index, frequency, entry_used, table_length,
                    output ready);
endinterface

interface nufm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [nufm_pkg::ENTRY_W-1:0] match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink   (input valid, found, match_index, output ready);
endinterface

// ----- src/nufm_table.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: entry table
// Single write port, single registered read port holding frequency and
// used mark of each entry.
// ----------------------------------------------------------------------------
module nufm_table (
    input  logic               i_clk,
    input  nufm_pkg::t_mem_req i_req,
    output nufm_pkg::t_mem_rsp o_rsp
);
    import nufm_pkg::*;

    t_mem_rsp r_mem [TABLE_DEPTH];
    t_mem_rsp r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= '{freq: i_req.wfreq, used: i_req.wused};
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_rsp = r_rd;

endmodule

// ----- src/nufm_cmp.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: compare unit
// Tests one table frequency against the tolerance window of the query and
// gives its absolute distance from the query.
// ----------------------------------------------------------------------------
module nufm_cmp (
    input  logic [nufm_pkg::FREQ_W-1:0] i_freq,
    input  logic [nufm_pkg::FREQ_W-1:0] i_query,
    output nufm_pkg::t_cmp_res          o_res
);
    import nufm_pkg::*;

    logic [KEY_W-1:0] freq_ext;
    logic [KEY_W-1:0] query_ext;

    assign freq_ext  = {1'b0, i_freq};
    assign query_ext = {1'b0, i_query};

    always_comb begin
        o_res.below_lo = (freq_ext + HALF_HZ) < query_ext;
        o_res.below_hi = freq_ext < (query_ext + HALF_HZ);
        if (i_query >= i_freq) begin
            o_res.diff = i_query - i_freq;
        end else begin
            o_res.diff = i_freq - i_query;
        end
    end

endmodule

// ----- src/nufm_seq.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: sequencer
// Takes items, writes entries, runs the lower-bound search and the window
// scan through the table and the compare unit, and hands out one result.
// ----------------------------------------------------------------------------
module nufm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    nufm_in_if.sink                      i_item,
    output nufm_pkg::t_mem_req           o_mem_req,
    input  nufm_pkg::t_mem_rsp           i_mem_rsp,
    output logic [nufm_pkg::FREQ_W-1:0]  o_query,
    input  nufm_pkg::t_cmp_res           i_cmp,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic                         o_res_found,
    output logic [nufm_pkg::ENTRY_W-1:0] o_res_index
);
    import nufm_pkg::*;

    t_state            r_state, n_state;
    logic [FREQ_W-1:0] r_query, n_query;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_first, n_first;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_mid, n_mid;
    logic              r_have, n_have;
    logic [IDX_W-1:0]  r_best, n_best;
    logic [FREQ_W-1:0] r_best_diff, n_best_diff;

    logic              accept;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  sat_len;

    assign accept = i_item.valid && i_item.ready;
    assign half   = r_len >> 1;
    assign mid    = r_first + half;

    always_comb begin
        if (32'(i_item.table_length) > TABLE_DEPTH) begin
            sat_len = CNT_W'(TABLE_DEPTH);
        end else begin
            sat_len = CNT_W'(i_item.table_length);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.mode == MODE_QUERY) ? ST_BS_RD : ST_DONE;
                end
            end
            ST_BS_RD: begin
                n_state = (r_len == '0) ? ST_SC_RD : ST_BS_CMP;
            end
            ST_BS_CMP: begin
                n_state = ST_BS_RD;
            end
            ST_SC_RD: begin
                n_state = (r_first < r_count) ? ST_SC_CMP : ST_DONE;
            end
            ST_SC_CMP: begin
                n_state = i_cmp.below_hi ? ST_SC_RD : ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_item.ready    = 1'b0;
        o_res_valid     = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = IDX_W'(i_item.entry_index);
        o_mem_req.wfreq = i_item.frequency;
        o_mem_req.wused = i_item.entry_used;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = r_first[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                o_mem_req.we = i_item.valid && (i_item.mode == MODE_WRITE)
                               && (32'(i_item.entry_index) < TABLE_DEPTH);
            end
            ST_BS_RD: begin
                o_mem_req.re    = (r_len != '0);
                o_mem_req.raddr = mid[IDX_W-1:0];
            end
            ST_SC_RD: begin
                o_mem_req.re = (r_first < r_count);
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_query     = r_query;
        n_count     = r_count;
        n_first     = r_first;
        n_len       = r_len;
        n_mid       = r_mid;
        n_have      = r_have;
        n_best      = r_best;
        n_best_diff = r_best_diff;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_query = i_item.frequency;
                    n_count = sat_len;
                    n_first = '0;
                    n_len   = sat_len;
                    n_have  = 1'b0;
                end
            end
            ST_BS_RD: begin
                n_mid = mid;
            end
            ST_BS_CMP: begin
                if (i_cmp.below_lo) begin
                    n_first = r_mid + CNT_W'(1);
                    n_len   = r_len - half - CNT_W'(1);
                end else begin
                    n_len = half;
                end
            end
            ST_SC_CMP: begin
                if (i_cmp.below_hi) begin
                    if (!i_mem_rsp.used && (!r_have || i_cmp.diff < r_best_diff)) begin
                        n_have      = 1'b1;
                        n_best      = r_first[IDX_W-1:0];
                        n_best_diff = i_cmp.diff;
                    end
                    n_first = r_first + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query     <= n_query;
        r_count     <= n_count;
        r_first     <= n_first;
        r_len       <= n_len;
        r_mid       <= n_mid;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_diff <= n_best_diff;
    end

    assign o_query     = r_query;
    assign o_res_found = r_have && ({1'b0, r_best_diff} < HALF_HZ);
    assign o_res_index = o_res_found ? ENTRY_W'(r_best) : '0;

endmodule

// ----- src/nearest_unused_frequency_match.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: top level
// Sorted frequency table with used marks and a nearest unused entry search
// within half a hertz of a query.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries input items. mode 0 writes frequency and used mark at
//   entry_index; mode 1 searches the first table_length entries (capped at
//   the table depth) for the closest unused entry strictly within 128 units.
//   o_result carries exactly one transfer per item: found and match_index,
//   both zero for writes and for queries without a match.
//   A write passes from its transfer to the done state and from there into
//   the result register. A query runs lower-bound steps (log2 of the length
//   plus one, at most 9 steps for 256 entries), each a table read and a
//   compare, then one read and compare per entry scanned in the window; all
//   of it is set by the single read port of the table.
//   One item is in work at a time; i_item.ready is high only when idle.
//   The result register lets the next item start while a result waits.
//   When o_result is stalled, a finished item holds until the register frees.
//   Reset clears the control state; table contents are undefined until
//   written.
// ----------------------------------------------------------------------------
module nearest_unused_frequency_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nufm_in_if.sink     i_item,
    nufm_out_if.source  o_result
);
    import nufm_pkg::*;

    t_mem_req          mem_req;
    t_mem_rsp          mem_rsp;
    t_cmp_res          cmp_res;
    logic [FREQ_W-1:0] query;
    logic              res_valid;
    logic              res_ready;
    logic              res_found;
    logic [ENTRY_W-1:0] res_index;

    logic               r_out_valid;
    logic               r_out_found;
    logic [ENTRY_W-1:0] r_out_index;

    nufm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_mem_req   (mem_req),
        .i_mem_rsp   (mem_rsp),
        .o_query     (query),
        .i_cmp       (cmp_res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_found (res_found),
        .o_res_index (res_index)
    );

    nufm_table u_table (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    nufm_cmp u_cmp (
        .i_freq  (mem_rsp.freq),
        .i_query (query),
        .o_res   (cmp_res)
    );

    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_found <= res_found;
            r_out_index <= res_index;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out_found;
    assign o_result.match_index = r_out_index;

endmodule

// ----- tb/sv/tb_nearest_unused_frequency_match.sv -----
// ----------------------------------------------------------------------------
// Nearest unused frequency match: testbench
// Drives write and query items through the valid/ready input channel and
// checks every result transfer against a predictor that keeps its own copy
// of the frequency table. It builds sorted tables with random spacing and
// used marks, then aims queries at the entries, at the exact half hertz edge
// and at random points. It runs under varied sender and receiver idling,
// with a long receiver hold-off and a sender pause until the block is empty.
// ----------------------------------------------------------------------------
module tb_nearest_unused_frequency_match;
    timeunit 1ns;
    timeprecision 1ps;
    import nufm_pkg::*;

    localparam int                WATCHDOG_LIMIT  = 5000;
    localparam int                DRAIN_CYCLES    = 40;
    localparam int                ITEMS_PER_PHASE = 570;
    localparam int                RX_HOLD_CYCLES  = 400;
    localparam longint            HALF_WINDOW     = 128;
    localparam logic [FREQ_W-1:0] FREQ_MAX        = '1;

    typedef struct {
        logic               mode;
        logic [ENTRY_W-1:0] entry_index;
        logic [FREQ_W-1:0]  frequency;
        logic               entry_used;
        logic [LEN_W-1:0]   table_length;
    } t_freq_item;

    typedef struct {
        logic               found;
        logic [ENTRY_W-1:0] match_index;
    } t_freq_match;

    class freq_match_scoreboard;
        logic [FREQ_W-1:0] freq_table [TABLE_DEPTH];
        logic              used_mark  [TABLE_DEPTH];
        t_freq_match       expected_matches [$];
        int                errors;

        function t_freq_match nearest_unused(logic [FREQ_W-1:0] query,
                                             logic [LEN_W-1:0] length);
            t_freq_match m;
            int          count;
            int          first;
            int          span;
            int          half;
            int          mid;
            int          i;
            int          best;
            longint      lo;
            longint      hi;
            longint      d;
            longint      best_d;
            bit          have;
            m.found       = 1'b0;
            m.match_index = '0;
            count = (length > TABLE_DEPTH) ? TABLE_DEPTH : int'(length);
            lo    = longint'(query) - HALF_WINDOW;
            hi    = longint'(query) + HALF_WINDOW;
            first = 0;
            span  = count;
            while (span > 0) begin
                half = span >> 1;
                mid  = first + half;
                if (longint'(freq_table[mid]) < lo) begin
                    first = mid + 1;
                    span  = span - half - 1;
                end else begin
                    span = half;
                end
            end
            have   = 1'b0;
            best   = 0;
            best_d = 0;
            i      = first;
            while (i < count && longint'(freq_table[i]) < hi) begin
                if (!used_mark[i]) begin
                    d = longint'(query) - longint'(freq_table[i]);
                    if (d < 0) d = -d;
                    if (!have || d < best_d) begin
                        have   = 1'b1;
                        best_d = d;
                        best   = i;
                    end
                end
                i++;
            end
            if (have && best_d < HALF_WINDOW) begin
                m.found       = 1'b1;
                m.match_index = ENTRY_W'(best);
            end
            return m;
        endfunction

        function void note_item(t_freq_item item);
            t_freq_match m;
            m.found       = 1'b0;
            m.match_index = '0;
            if (item.mode == MODE_WRITE) begin
                if (item.entry_index < TABLE_DEPTH) begin
                    freq_table[item.entry_index] = item.frequency;
                    used_mark[item.entry_index]  = item.entry_used;
                end
            end else begin
                m = nearest_unused(item.frequency, item.table_length);
            end
            expected_matches.push_back(m);
        endfunction

        function void check_result(logic found, logic [ENTRY_W-1:0] match_index);
            t_freq_match m;
            if (expected_matches.size() == 0) begin
                $error("unexpected result transfer: found=%0b match_index=%0d",
                       found, match_index);
                errors++;
                return;
            end
            m = expected_matches.pop_front();
            if (found !== m.found) begin
                $error("found: expected %0b, actual %0b", m.found, found);
                errors++;
            end
            if (match_index !== m.match_index) begin
                $error("match_index: expected %0d, actual %0d", m.match_index, match_index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    nufm_in_if  item_if ();
    nufm_out_if result_if ();

    nearest_unused_frequency_match dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    freq_match_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int items_sent   = 0;
    int stall_cycles = 0;
    int written_prefix = 0;
    bit written [TABLE_DEPTH];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(t_freq_item item);
        if ($urandom_range(99) < tx_idle_pct) begin
            item_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        item_if.valid        <= 1'b1;
        item_if.mode         <= item.mode;
        item_if.entry_index  <= item.entry_index;
        item_if.frequency    <= item.frequency;
        item_if.entry_used   <= item.entry_used;
        item_if.table_length <= item.table_length;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_item(item);
        if (item.mode == MODE_WRITE) begin
            written[item.entry_index] = 1'b1;
            while (written_prefix < TABLE_DEPTH && written[written_prefix]) written_prefix++;
        end
        items_sent++;
    endtask

    task automatic write_entry(int idx, logic [FREQ_W-1:0] freq, logic used);
        t_freq_item item;
        item.mode         = MODE_WRITE;
        item.entry_index  = ENTRY_W'(idx);
        item.frequency    = freq;
        item.entry_used   = used;
        item.table_length = LEN_W'($urandom_range(511));
        send_item(item);
    endtask

    task automatic query_freq(logic [FREQ_W-1:0] freq, int length);
        t_freq_item item;
        item.mode         = MODE_QUERY;
        item.entry_index  = ENTRY_W'($urandom_range(255));
        item.frequency    = freq;
        item.entry_used   = 1'($urandom_range(1));
        item.table_length = LEN_W'(length);
        send_item(item);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (sb.expected_matches.size() != 0) @(posedge i_clk);
    endtask

    task automatic build_sorted_table(int count);
        longint f;
        int     kind;
        case ($urandom_range(3))
            0:       f = 0;
            1:       f = longint'(FREQ_MAX) - $urandom_range(count * 40);
            default: f = $urandom_range(FREQ_MAX);
        endcase
        for (int j = 0; j < count; j++) begin
            write_entry(j, FREQ_W'(f), $urandom_range(99) < 30);
            kind = $urandom_range(9);
            if (kind < 4)      f += $urandom_range(20);
            else if (kind < 8) f += $urandom_range(300);
            else               f += $urandom_range(100000);
            if (f > longint'(FREQ_MAX)) f = FREQ_MAX;
        end
    endtask

    task automatic query_table(int count, int queries);
        longint q;
        longint aim;
        int     kind;
        int     pick;
        int     length;
        repeat (queries) begin
            aim  = sb.freq_table[$urandom_range(count - 1)];
            kind = $urandom_range(9);
            if (kind < 7)       q = aim + int'($urandom_range(320)) - 160;
            else if (kind == 7) q = $urandom_range(FREQ_MAX);
            else                q = $urandom_range(1) ? aim + HALF_WINDOW : aim - HALF_WINDOW;
            if (q < 0) q = 0;
            if (q > longint'(FREQ_MAX)) q = FREQ_MAX;
            pick = $urandom_range(19);
            if (pick < 15)      length = count;
            else if (pick < 17) length = $urandom_range(written_prefix);
            else if (pick < 18 && written_prefix == TABLE_DEPTH)
                length = $urandom_range(511, TABLE_DEPTH + 1);
            else                length = $urandom_range(count);
            query_freq(FREQ_W'(q), length);
        end
    endtask

    task automatic table_round();
        int count;
        if ($urandom_range(9) == 0) count = $urandom_range(256, 25);
        else                        count = $urandom_range(24, 1);
        build_sorted_table(count);
        // disorder a few entries now and then
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(3, 1))
                write_entry($urandom_range(count - 1), FREQ_W'($urandom_range(FREQ_MAX)),
                            1'($urandom_range(1)));
        end
        query_table(count, $urandom_range(12, 4) + count / 8);
    endtask

    task automatic random_phase(int tx_pct, int rx_pct, int target);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (items_sent < target) table_round();
        wait_drained();
    endtask

    task automatic directed_items();
        query_freq('0, 0);
        query_freq(FREQ_MAX, 0);
        write_entry(0, 24'h000000, 1'b0);
        write_entry(1, 24'h000080, 1'b0);
        write_entry(2, 24'h0000C8, 1'b1);
        write_entry(3, 24'h00012C, 1'b0);
        write_entry(4, 24'h00012C, 1'b0);
        write_entry(5, 24'h800000, 1'b0);
        write_entry(6, 24'hFFFF80, 1'b1);
        write_entry(7, FREQ_MAX, 1'b0);
        write_entry(TABLE_DEPTH - 1, FREQ_MAX, 1'b1);
        query_freq(24'h000000, 8);
        query_freq(24'h000040, 8);
        query_freq(24'h0000FA, 8);
        query_freq(24'h00012C, 8);
        query_freq(24'h7FFF80, 8);
        query_freq(FREQ_MAX, 8);
        query_freq(24'hFFFF80, 8);
        query_freq(24'h0000C8, 3);
        query_freq(24'h555555, 8);
        query_freq(24'h00012C, 1);
        write_entry(3, 24'h00012C, 1'b1);
        query_freq(24'h00012C, 8);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        item_if.valid          = 1'b0;
        item_if.mode           = MODE_WRITE;
        item_if.entry_index    = '0;
        item_if.frequency      = '0;
        item_if.entry_used     = 1'b0;
        item_if.table_length   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 19;
        rx_idle_pct = 65;
        directed_items();
        wait_drained();

        build_sorted_table(TABLE_DEPTH);
        rx_hold_left = RX_HOLD_CYCLES;
        query_table(TABLE_DEPTH, 20);
        wait_drained();
        query_table(TABLE_DEPTH, 20);
        random_phase(19, 65, ITEMS_PER_PHASE);
        random_phase(65, 19, 2 * ITEMS_PER_PHASE);
        random_phase(0, 0, 3 * ITEMS_PER_PHASE);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_matches.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready)
                sb.check_result(result_if.found, result_if.match_index);
            if (rx_hold_left > 0) begin
                result_if.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ----- nearest_unused_frequency_match.f -----
src/nufm_pkg.sv
src/nufm_if.sv
src/nufm_table.sv
src/nufm_cmp.sv
src/nufm_seq.sv
src/nearest_unused_frequency_match.sv
tb/sv/tb_nearest_unused_frequency_match.sv
